/* hdl/htfi_pkg.sv */
package htfi_pkg;

   localparam int KEY_W   = 32;
   localparam int SLOT_W  = 12;
   localparam int COUNT_W = 13;
   localparam int PROBE_W = 13;

   localparam logic [KEY_W-1:0] HASH_MUL_A = 32'h7feb352d;
   localparam logic [KEY_W-1:0] HASH_MUL_B = 32'h846ca68b;

   localparam logic [PROBE_W-1:0] PROBE_LIMIT_RESET = 13'd1000;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

   localparam int JOB_QUEUE_DEPTH    = 2;
   localparam int RESULT_QUEUE_DEPTH = 2;

   typedef enum logic [0:0] {
      OP_FIND_OR_INSERT = 1'b0,
      OP_FIND_ONLY      = 1'b1
   } htfi_op_type;

   typedef enum logic [1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_INSERTED = 2'd1,
      STATUS_MISS     = 2'd2,
      STATUS_FULL     = 2'd3
   } htfi_status_type;

   typedef enum logic [1:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_PROBE
   } htfi_state_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      htfi_status_type    status;
      logic [COUNT_W-1:0] entries_used;
   } htfi_result_type;

endpackage

/* hdl/htfi_ram.sv */
module htfi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/htfi_fifo.sv */
module htfi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/htfi_front.sv */
module htfi_front #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     hold,
   input  logic                     push,
   output logic                     full,
   input  htfi_pkg::htfi_op_type    req_op,
   input  logic [31:0]              req_key,
   output logic                     job_push,
   input  logic                     job_full,
   output htfi_pkg::htfi_op_type    job_op,
   output logic [31:0]              job_key,
   output logic [$clog2(DEPTH)-1:0] job_home
);

   import htfi_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic             adv;
   logic [KEY_W-1:0] a_mix;
   logic [KEY_W-1:0] a_mul_in;
   logic [KEY_W-1:0] a_mul_ff;
   logic [KEY_W-1:0] a_key_ff;
   htfi_op_type      a_op_ff;
   logic             a_vld_ff;
   logic             a_vld_in;
   logic [KEY_W-1:0] b_mix;
   logic [KEY_W-1:0] b_mul_in;
   logic [KEY_W-1:0] b_mul_ff;
   logic [KEY_W-1:0] b_key_ff;
   htfi_op_type      b_op_ff;
   logic             b_vld_ff;
   logic [KEY_W-1:0] fin;

   // advance the whole pipe unless the last stage is blocked
   assign adv      = !(b_vld_ff && job_full);
   assign full     = hold || !adv;
   assign a_vld_in = push && !hold;

   assign a_mix    = req_key ^ (req_key >> 16);
   assign a_mul_in = a_mix * HASH_MUL_A;
   assign b_mix    = a_mul_ff ^ (a_mul_ff >> 15);
   assign b_mul_in = b_mix * HASH_MUL_B;
   assign fin      = b_mul_ff ^ (b_mul_ff >> 16);

   assign job_push = b_vld_ff && !job_full;
   assign job_op   = b_op_ff;
   assign job_key  = b_key_ff;
   assign job_home = fin[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mul_ff <= a_mul_in;
         a_key_ff <= req_key;
         a_op_ff  <= req_op;
         b_mul_ff <= b_mul_in;
         b_key_ff <= a_key_ff;
         b_op_ff  <= a_op_ff;
      end
   end

endmodule

/* hdl/htfi_back.sv */
module htfi_back #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [12:0]              max_probes,
   input  logic                     job_empty,
   input  htfi_pkg::htfi_op_type    job_op,
   input  logic [31:0]              job_key,
   input  logic [$clog2(DEPTH)-1:0] job_home,
   output logic                     job_pop,
   input  logic                     res_full,
   output logic                     res_push,
   output htfi_pkg::htfi_result_type res_data,
   output logic                     clearing
);

   import htfi_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int ROW_W = KEY_W + 1;

   htfi_state_type     state_ff;
   htfi_state_type     state_in;
   logic [IDX_W-1:0]   clr_ff;
   logic [IDX_W-1:0]   clr_in;
   logic [IDX_W-1:0]   pos_ff;
   logic [IDX_W-1:0]   pos_in;
   logic [PROBE_W-1:0] passed_ff;
   logic [PROBE_W-1:0] passed_in;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;
   htfi_op_type        op_ff;
   htfi_op_type        op_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ROW_W-1:0]   rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ROW_W-1:0]   wr_data;

   logic               go;
   logic               row_valid;
   logic               row_match;
   logic               end_empty;
   logic               end_found;
   logic               end_full;
   logic               probe_done;
   logic               clear_done;

   // each row holds the valid bit above the key
   htfi_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign go         = !res_full;
   assign row_valid  = rd_data[KEY_W];
   assign row_match  = (rd_data[KEY_W-1:0] == key_ff);
   assign end_empty  = !row_valid;
   assign end_found  = row_valid && row_match;
   assign end_full   = row_valid && !row_match && (passed_ff == max_probes);
   assign probe_done = go && (end_empty || end_found || end_full);
   assign clear_done = (clr_ff == IDX_W'(DEPTH - 1));
   assign clearing   = (state_ff == STATE_CLEAR);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_CLEAR: begin
            if (clear_done) begin
               state_in = STATE_IDLE;
            end
         end
         STATE_IDLE: begin
            if (!job_empty) begin
               state_in = STATE_PROBE;
            end
         end
         STATE_PROBE: begin
            if (probe_done) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_CLEAR;
         end
      endcase
   end

   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = pos_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = '0;
      job_pop   = 1'b0;
      res_push  = 1'b0;
      res_data  = '0;
      clr_in    = clr_ff;
      pos_in    = pos_ff;
      passed_in = passed_ff;
      key_in    = key_ff;
      op_in     = op_ff;
      count_in  = count_ff;
      case (state_ff)
         STATE_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
         end
         STATE_IDLE: begin
            if (!job_empty) begin
               job_pop   = 1'b1;
               rd_en     = 1'b1;
               rd_addr   = job_home;
               pos_in    = job_home;
               passed_in = '0;
               key_in    = job_key;
               op_in     = job_op;
            end
         end
         STATE_PROBE: begin
            if (go) begin
               if (end_empty) begin
                  res_push = 1'b1;
                  if (op_ff == OP_FIND_ONLY) begin
                     res_data.status = STATUS_MISS;
                  end else begin
                     wr_en           = 1'b1;
                     wr_data         = {1'b1, key_ff};
                     res_data.slot   = SLOT_W'(pos_ff);
                     res_data.status = STATUS_INSERTED;
                     if (count_ff != COUNT_MAX) begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
               end else if (end_found) begin
                  res_push        = 1'b1;
                  res_data.slot   = SLOT_W'(pos_ff);
                  res_data.status = STATUS_FOUND;
               end else if (end_full) begin
                  res_push        = 1'b1;
                  res_data.status = STATUS_FULL;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = pos_ff + IDX_W'(1);
                  pos_in    = pos_ff + IDX_W'(1);
                  passed_in = passed_ff + PROBE_W'(1);
               end
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
      res_data.entries_used = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      passed_ff <= passed_in;
      key_ff    <= key_in;
      op_ff     <= op_in;
   end

endmodule

/* hdl/hash_table_find_or_insert_unit.sv */
// Open-addressing hash table with linear probing. Each request carries a
// 32-bit key and an operation (find-or-insert, or find-only) and gets exactly
// one response: the slot where the key was found or inserted, a status
// (found, inserted, not found, table full) and the number of stored keys
// after the request. The home slot is a two-multiply xor-shift hash of the
// key, taken modulo TABLE_DEPTH (a power of two, 16 to 65536). The search
// gives up with table full after passing more than max_probes occupied
// slots; max_probes (reset 1000) is written through the csr channel; the user
// must write it only while the block is idle, as the block does not enforce
// this. The slot response is the low 12 bits of the index. The hash takes
// two pipelined multiply stages in the front end, which keeps hashing later
// requests while the back end works. The back end takes a request and reads
// its home slot, then reads the following slots in turn, stalling while the
// result queue is full; the slot store has a single read port, and the back
// end finishes one request before it takes the next. After reset a clearing
// pass writes every slot empty, one slot per cycle, and full stays high until
// the pass is done.
module hash_table_find_or_insert_unit #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        push,
   output logic        full,
   input  logic        req_operation,
   input  logic [31:0] req_key,
   // response side
   input  logic        pop,
   output logic        empty,
   output logic [11:0] rsp_slot,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_entries_used,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_max_probes
);

   import htfi_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int JOB_W = 1 + KEY_W + IDX_W;

   logic [PROBE_W-1:0] max_probes_ff;
   logic [PROBE_W-1:0] max_probes_in;

   logic               clearing;
   logic               job_push;
   logic               job_full;
   logic               job_pop;
   logic               job_empty;
   htfi_op_type        fe_op;
   logic [KEY_W-1:0]   fe_key;
   logic [IDX_W-1:0]   fe_home;
   logic [JOB_W-1:0]   job_wr;
   logic [JOB_W-1:0]   job_rd;
   htfi_op_type        be_op;
   logic [KEY_W-1:0]   be_key;
   logic [IDX_W-1:0]   be_home;

   logic               res_push;
   logic               res_full;
   htfi_result_type    res_wr;
   htfi_result_type    res_rd;

   // the probe limit register always takes writes
   assign csr_ready     = 1'b1;
   assign max_probes_in = (csr_valid && csr_ready) ? csr_max_probes : max_probes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_probes_ff <= PROBE_LIMIT_RESET;
      end else begin
         max_probes_ff <= max_probes_in;
      end
   end

   // front end: accept and hash; hold off while the store is being cleared
   htfi_front #(
      .DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .hold     (clearing),
      .push     (push),
      .full     (full),
      .req_op   (htfi_op_type'(req_operation)),
      .req_key  (req_key),
      .job_push (job_push),
      .job_full (job_full),
      .job_op   (fe_op),
      .job_key  (fe_key),
      .job_home (fe_home)
   );

   // hashed requests wait here so either side can stall alone
   assign job_wr            = {fe_op, fe_key, fe_home};
   assign be_op             = htfi_op_type'(job_rd[JOB_W-1]);
   assign {be_key, be_home} = job_rd[JOB_W-2:0];

   htfi_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rd),
      .empty     (job_empty)
   );

   // back end: probe the slot store, insert, count
   htfi_back #(
      .DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .max_probes (max_probes_ff),
      .job_empty  (job_empty),
      .job_op     (be_op),
      .job_key    (be_key),
      .job_home   (be_home),
      .job_pop    (job_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_data   (res_wr),
      .clearing   (clearing)
   );

   // finished responses wait here until popped
   htfi_fifo #(
      .WIDTH ($bits(htfi_result_type)),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_wr),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_rd),
      .empty     (empty)
   );

   assign rsp_slot         = res_rd.slot;
   assign rsp_status       = res_rd.status;
   assign rsp_entries_used = res_rd.entries_used;

endmodule

/* verif/testbench.sv */
module testbench;
   import htfi_pkg::*;

   // Table depth of the instance; the home slot is the low bits of the hash.
   localparam int DEPTH = 4096;
   // Cycles without any accepted request, response or register write before
   // the run is called hung. The clearing pass after reset holds full high
   // while it writes every slot. The longest search here walks a cluster of a
   // few hundred slots. The limit covers both many times over.
   localparam int unsigned STALL_LIMIT = 40000;
   // Home slots of the crowded region; its cluster wraps from the last slot
   // to slot 0.
   localparam int unsigned CLUSTER_BASE = DEPTH - 16;
   localparam int CLUSTER_KEYS = 256;
   localparam int PHASES = 10;
   localparam int PHASE_REQUESTS = 185;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_operation = 1'b0;
   logic [31:0] req_key = '0;
   logic        pop = 1'b0;
   logic        empty;
   logic [11:0] rsp_slot;
   logic [1:0]  rsp_status;
   logic [12:0] rsp_entries_used;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_max_probes = '0;

   // Shadow copy of the table, kept in step with the accepted requests.
   logic [KEY_W-1:0]   shadow_key [DEPTH];
   bit                 shadow_used [DEPTH];
   logic [COUNT_W-1:0] shadow_count = '0;
   logic [PROBE_W-1:0] probe_limit = PROBE_LIMIT_RESET;
   logic [KEY_W-1:0]   stored_keys [$];

   // Responses still owed by the block, oldest first.
   htfi_result_type expected_responses [$];

   logic [KEY_W-1:0] wrap_keys [4];
   logic [KEY_W-1:0] cluster_keys [CLUSTER_KEYS];

   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0;

   logic [7:0] pop_pattern = 8'hFF;
   logic [2:0] pop_phase = '0;

   hash_table_find_or_insert_unit #(
      .TABLE_DEPTH(DEPTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .pop             (pop),
      .empty           (empty),
      .rsp_slot        (rsp_slot),
      .rsp_status      (rsp_status),
      .rsp_entries_used(rsp_entries_used),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_probes  (csr_max_probes)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Xor-shift-multiply hash, reduced to the table depth.
   function automatic int unsigned home_of(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] h;
      h = key ^ (key >> 16);
      h = h * HASH_MUL_A;
      h = h ^ (h >> 15);
      h = h * HASH_MUL_B;
      h = h ^ (h >> 16);
      return h % DEPTH;
   endfunction

   // Walk the shadow table from the home slot and apply the request to it.
   function automatic htfi_result_type probe_table(input htfi_op_type op,
                                                   input logic [KEY_W-1:0] key);
      htfi_result_type outcome;
      int unsigned pos;
      int unsigned passed;
      bit done;
      pos = home_of(key);
      passed = 0;
      done = 0;
      outcome.slot = '0;
      outcome.status = STATUS_MISS;
      while (!done) begin
         if (!shadow_used[pos]) begin
            if (op == OP_FIND_ONLY) begin
               outcome.status = STATUS_MISS;
            end else begin
               shadow_key[pos] = key;
               shadow_used[pos] = 1'b1;
               if (shadow_count < COUNT_MAX) shadow_count++;
               stored_keys.push_back(key);
               outcome.slot = SLOT_W'(pos);
               outcome.status = STATUS_INSERTED;
            end
            done = 1;
         end else if (shadow_key[pos] == key) begin
            outcome.slot = SLOT_W'(pos);
            outcome.status = STATUS_FOUND;
            done = 1;
         end else begin
            pos = (pos + 1) % DEPTH;
            passed++;
            if (passed > probe_limit) begin
               outcome.status = STATUS_FULL;
               done = 1;
            end
         end
      end
      outcome.entries_used = shadow_count;
      return outcome;
   endfunction

   // Draw random keys until one lands on the given home slot.
   function automatic logic [KEY_W-1:0] key_homed_at(input int unsigned slot);
      logic [KEY_W-1:0] key;
      key = $urandom;
      while (home_of(key) != slot) key = $urandom;
      return key;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Send one request. Work in bursts: at the start of a burst, drop push
   // for a random gap. Hold push high across back-to-back requests.
   task automatic send_request(input htfi_op_type op, input logic [KEY_W-1:0] key);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push <= 1'b1;
      req_operation <= op;
      req_key <= key;
      do @(posedge clock); while (full !== 1'b0);
      expected_responses.push_back(probe_table(op, key));
   endtask

   // Stop sending and hold until every owed response has come back.
   task automatic wait_for_responses();
      push <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_responses.size() != 0);
   endtask

   // Write the probe limit with the block idle.
   task automatic write_probe_limit(input logic [PROBE_W-1:0] value);
      wait_for_responses();
      csr_valid <= 1'b1;
      csr_max_probes <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      probe_limit = value;
      csr_valid <= 1'b0;
   endtask

   // Misses, inserts and hits on the extreme keys, at the reset probe limit.
   task automatic test_basic_requests();
      send_request(OP_FIND_ONLY, 32'h0000_0000);
      send_request(OP_FIND_OR_INSERT, 32'h0000_0000);
      send_request(OP_FIND_ONLY, 32'h0000_0000);
      send_request(OP_FIND_OR_INSERT, 32'h0000_0000);
      send_request(OP_FIND_OR_INSERT, 32'hFFFF_FFFF);
      send_request(OP_FIND_ONLY, 32'hFFFF_FFFF);
      // The old empty marker is an ordinary key here.
      send_request(OP_FIND_OR_INSERT, 32'hDEAD_BEEF);
      send_request(OP_FIND_ONLY, 32'hDEAD_BEEF);
      send_request(OP_FIND_ONLY, 32'h8000_0000);
      send_request(OP_FIND_OR_INSERT, 32'h0000_0001);
   endtask

   // Pile keys onto the last slot so the probe wraps to slot 0.
   task automatic test_wraparound();
      int i;
      int j;
      bit fresh;
      for (i = 0; i < 4; i++) begin
         fresh = 0;
         while (!fresh) begin
            wrap_keys[i] = key_homed_at(DEPTH - 1);
            fresh = 1;
            for (j = 0; j < i; j++) if (wrap_keys[j] == wrap_keys[i]) fresh = 0;
         end
      end
      for (i = 0; i < 3; i++) send_request(OP_FIND_OR_INSERT, wrap_keys[i]);
      send_request(OP_FIND_ONLY, wrap_keys[2]);
      send_request(OP_FIND_ONLY, wrap_keys[3]);
   endtask

   // With no probes allowed, the first occupied non-matching slot is full.
   task automatic test_zero_probe_limit();
      write_probe_limit('0);
      send_request(OP_FIND_OR_INSERT, wrap_keys[3]);
      send_request(OP_FIND_ONLY, wrap_keys[1]);
      send_request(OP_FIND_ONLY, wrap_keys[0]);
      send_request(OP_FIND_OR_INSERT, $urandom);
   endtask

   task automatic test_largest_probe_limit();
      write_probe_limit('1);
      send_request(OP_FIND_OR_INSERT, wrap_keys[3]);
      send_request(OP_FIND_ONLY, wrap_keys[3]);
      send_request(OP_FIND_ONLY, wrap_keys[2]);
   endtask

   // Phases of mixed traffic, each under its own probe limit. A crowded
   // region near the end of the table builds a long wrapping cluster.
   task automatic test_random_traffic();
      logic [PROBE_W-1:0] limits [PHASES];
      int phase;
      int n;
      int pick;
      int i;
      limits = '{13'd1000, 13'd0, 13'd1, 13'd3, 13'd8191,
                 13'd4096, 13'd16, 13'd200, 13'd0, 13'd1000};
      limits[8] = PROBE_W'($urandom_range(0, 8191));
      for (i = 0; i < CLUSTER_KEYS; i++) begin
         cluster_keys[i] = $urandom;
         while (home_of(cluster_keys[i]) < CLUSTER_BASE) cluster_keys[i] = $urandom;
      end
      for (phase = 0; phase < PHASES; phase++) begin
         write_probe_limit(limits[phase]);
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               send_request(OP_FIND_OR_INSERT, $urandom);
            end else if (pick < 50) begin
               send_request(OP_FIND_OR_INSERT,
                            cluster_keys[$urandom_range(0, CLUSTER_KEYS - 1)]);
            end else if (pick < 65 && stored_keys.size() != 0) begin
               send_request(OP_FIND_ONLY,
                            stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            end else if (pick < 75 && stored_keys.size() != 0) begin
               send_request(OP_FIND_OR_INSERT,
                            stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            end else if (pick < 87) begin
               send_request(OP_FIND_ONLY, $urandom);
            end else begin
               send_request(OP_FIND_ONLY,
                            cluster_keys[$urandom_range(0, CLUSTER_KEYS - 1)]);
            end
         end
      end
   endtask

   // Receiver: pop on a rotating 8-bit pattern, reshuffled now and then,
   // including stretches of pop held high and long stalls.
   always @(posedge clock) begin
      pop <= pop_pattern[pop_phase];
      pop_phase <= pop_phase + 1'b1;
      if (pop_phase == 3'd7 && $urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               pop_pattern <= 8'hFF;
            end
            1: begin
               pop_pattern <= 8'h01;
            end
            default: begin
               pop_pattern <= 8'($urandom);
            end
         endcase
      end
   end

   // Check every popped response against the oldest owed one.
   always @(posedge clock) begin
      htfi_result_type want;
      if (!reset && pop && empty === 1'b0) begin
         if (expected_responses.size() == 0) begin
            report_error($sformatf("response with no request pending: slot %0d status %0d",
                                   rsp_slot, rsp_status));
         end else begin
            want = expected_responses.pop_front();
            if (rsp_slot !== want.slot)
               report_error($sformatf("slot expected %0d got %0d", want.slot, rsp_slot));
            if (rsp_status !== want.status)
               report_error($sformatf("status expected %0d got %0d",
                                      want.status, rsp_status));
            if (rsp_entries_used !== want.entries_used)
               report_error($sformatf("entries_used expected %0d got %0d",
                                      want.entries_used, rsp_entries_used));
         end
      end
   end

   // Count cycles in which nothing moves on any channel.
   always @(posedge clock) begin
      if ((push && full === 1'b0) || (pop && empty === 1'b0) ||
          (csr_valid && csr_ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("hash_table_find_or_insert_unit test failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_basic_requests();
      test_wraparound();
      test_zero_probe_limit();
      test_largest_probe_limit();
      test_random_traffic();
      wait_for_responses();
      // Give a stray extra response time to show up.
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("hash_table_find_or_insert_unit test passed");
      end else begin
         $display("hash_table_find_or_insert_unit test failed");
      end
      $finish;
   end

endmodule
